// ----- hdl/tfn_pkg.sv -----
`default_nettype none
package tfn_pkg;
    localparam int CW   = 24;              // coordinate width, Q12.12
    localparam int NW   = 16;              // normal component width, Q1.15
    localparam int EW   = CW + 1;          // edge vector width
    localparam int PW   = 2 * EW;          // edge product width
    localparam int XW   = PW + 1;          // cross component width, signed
    localparam int MW   = XW;              // cross magnitude width
    localparam int NB   = 30;              // normalized magnitude width
    localparam int SQW  = 2 * NB + 2;      // sum of squares width
    localparam int RW   = NB + 1;          // root width
    localparam int REMW = RW + 2;          // root remainder width
    localparam int DW   = NB + NW;         // dividend width
    localparam int CH   = 8;               // leading-one search chunk
    localparam int NCH  = (MW + CH - 1) / CH;
    localparam int LW   = $clog2(MW + 1);
    localparam int LCW  = $clog2(CH + 1);
    localparam int FD   = 16;              // queue depth
    localparam int FAW  = $clog2(FD);
    localparam int OCW  = $clog2(FD + 1);
    localparam int IDW  = ((9 * CW + 7) / 8) * 8;
    localparam int ODW  = ((3 * NW + 7) / 8) * 8;
    localparam logic [NW-1:0] QMAX = NW'((1 << (NW - 1)) - 1);

    typedef struct packed {
        logic [2:0][NB-1:0] mag;
        logic [2:0]         neg;
        logic               deg;
    } t_item;
endpackage
`default_nettype wire

// ----- hdl/tfn_front.sv -----
`default_nettype none
module tfn_front import tfn_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [IDW-1:0] i_data,
    output logic                o_valid,
    output t_item               o_item
);
    logic signed [CW-1:0] w_p [9];
    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic signed [PW-1:0] r_p [6];
    logic signed [XW-1:0] r_c [3];
    logic [MW-1:0]        r_mag4 [3];
    logic [MW-1:0]        r_mag5 [3];
    logic [MW-1:0]        r_mag6 [3];
    logic [2:0]           r_neg4, r_neg5, r_neg6;
    logic [NCH*CH-1:0]    w_pad;
    logic [NCH-1:0]       n_cnz, r_cnz;
    logic [LCW-1:0]       n_cbl [NCH];
    logic [LCW-1:0]       r_cbl [NCH];
    logic [LW-1:0]        n_len, r_len;
    logic [MW+NB-1:0]     w_sh [3];
    logic [6:0]           r_v;
    t_item                r_out;

    always_comb begin
        for (int k = 0; k < 9; k++) w_p[k] = i_data[k*CW +: CW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    // edges, products, cross terms, magnitudes
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_e1[i] <= {w_p[3+i][CW-1], w_p[3+i]} - {w_p[i][CW-1], w_p[i]};
            r_e2[i] <= {w_p[6+i][CW-1], w_p[6+i]} - {w_p[i][CW-1], w_p[i]};
        end
        r_p[0] <= r_e1[1] * r_e2[2];
        r_p[1] <= r_e1[2] * r_e2[1];
        r_p[2] <= r_e1[2] * r_e2[0];
        r_p[3] <= r_e1[0] * r_e2[2];
        r_p[4] <= r_e1[0] * r_e2[1];
        r_p[5] <= r_e1[1] * r_e2[0];
        for (int i = 0; i < 3; i++) begin
            r_c[i]    <= XW'(r_p[2*i]) - XW'(r_p[2*i+1]);
            r_neg4[i] <= r_c[i][XW-1];
            r_mag4[i] <= r_c[i][XW-1] ? MW'(-r_c[i]) : MW'(r_c[i]);
        end
    end

    // chunked leading-one search on the or of all magnitudes
    always_comb begin
        w_pad = (NCH*CH)'(r_mag4[0] | r_mag4[1] | r_mag4[2]);
        for (int j = 0; j < NCH; j++) begin
            n_cnz[j] = |w_pad[j*CH +: CH];
            n_cbl[j] = '0;
            for (int b = 0; b < CH; b++) begin
                if (w_pad[j*CH+b]) n_cbl[j] = LCW'(b + 1);
            end
        end
        n_len = '0;
        for (int j = 0; j < NCH; j++) begin
            if (r_cnz[j]) n_len = LW'(j * CH) + LW'(r_cbl[j]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) w_sh[i] = {r_mag6[i], {NB{1'b0}}} >> r_len;
    end

    always_ff @(posedge i_clk) begin
        r_cnz  <= n_cnz;
        r_cbl  <= n_cbl;
        r_mag5 <= r_mag4;
        r_neg5 <= r_neg4;
        r_len  <= n_len;
        r_mag6 <= r_mag5;
        r_neg6 <= r_neg5;
        for (int i = 0; i < 3; i++) r_out.mag[i] <= w_sh[i][NB-1:0];
        r_out.neg <= r_neg6;
        r_out.deg <= (r_len == '0);
    end

    assign o_valid = r_v[6];
    assign o_item  = r_out;
endmodule
`default_nettype wire

// ----- hdl/tfn_queue.sv -----
`default_nettype none
module tfn_queue import tfn_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output t_item      o_head,
    output logic       o_avail
);
    t_item          r_mem [FD];
    t_item          r_head;
    logic           r_hv;
    logic [FAW-1:0] r_wp, r_rp;
    logic [OCW-1:0] r_cnt;
    logic           w_load, w_rd, w_bypass, w_wr;

    // registered head; an empty store lets a push go straight to the head
    assign w_load   = !r_hv || i_pop;
    assign w_rd     = w_load && (r_cnt != '0);
    assign w_bypass = w_load && (r_cnt == '0) && i_push;
    assign w_wr     = i_push && !w_bypass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_hv  <= 1'b0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + OCW'(w_wr) - OCW'(w_rd);
            if (w_load) r_hv <= w_rd || w_bypass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_item;
        if (w_rd) begin
            r_head <= r_mem[r_rp];
        end else if (w_bypass) begin
            r_head <= i_item;
        end
    end

    assign o_head  = r_head;
    assign o_avail = r_hv;
endmodule
`default_nettype wire

// ----- hdl/tfn_back.sv -----
`default_nettype none
module tfn_back import tfn_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_item i_item,
    input  wire logic  i_avail,
    output logic       o_pop,
    input  wire logic  i_ready,
    output logic       o_valid,
    output logic [NW-1:0] o_nx,
    output logic [NW-1:0] o_ny,
    output logic [NW-1:0] o_nz,
    output logic       o_deg
);
    logic              w_en;
    logic              r_v0, r_v1, r_v2, r_vp, r_ov;
    t_item             r_it0, r_it1, r_it2;
    logic [2*NB-1:0]   r_sq [3];
    logic [SQW-1:0]    r_m;
    logic [REMW-1:0]   r_rem  [RW];
    logic [RW-1:0]     r_root [RW];
    logic [SQW-1:0]    r_sm   [RW];
    t_item             r_sit  [RW];
    logic [RW-1:0]     r_sv;
    logic [DW-1:0]     r_pn [3];
    logic [RW-1:0]     r_pd;
    logic [2:0]        r_pneg;
    logic              r_pdeg;
    logic [RW:0]       r_dr  [NW][3];
    logic [NW-1:0]     r_dlo [NW][3];
    logic [NW-1:0]     r_dq  [NW][3];
    logic [RW-1:0]     r_dd  [NW];
    logic [2:0]        r_dneg [NW];
    logic              r_ddeg [NW];
    logic [NW-1:0]     r_dv;
    logic [NW-1:0]     n_o [3];
    logic [NW-1:0]     r_o [3];
    logic              r_odeg;

    assign w_en  = !r_ov || i_ready;
    assign o_pop = w_en && i_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0; r_v1 <= 1'b0; r_v2 <= 1'b0; r_vp <= 1'b0; r_ov <= 1'b0;
            r_sv <= '0;   r_dv <= '0;
        end else if (w_en) begin
            r_v0 <= o_pop;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_sv <= {r_sv[RW-2:0], r_v2};
            r_vp <= r_sv[RW-1];
            r_dv <= {r_dv[NW-2:0], r_vp};
            r_ov <= r_dv[NW-1];
        end
    end

    // squares and their sum
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_it0 <= i_item;
            r_it1 <= r_it0;
            r_it2 <= r_it1;
            for (int i = 0; i < 3; i++) r_sq[i] <= r_it0.mag[i] * r_it0.mag[i];
            r_m <= SQW'(r_sq[0]) + SQW'(r_sq[1]) + SQW'(r_sq[2]);
        end
    end

    // integer square root, two radicand bits per stage
    for (genvar s = 0; s < RW; s++) begin : g_sqrt
        logic [REMW-1:0] w_rin, w_cur, w_t;
        logic [RW-1:0]   w_qin;
        logic [SQW-1:0]  w_min;
        t_item           w_iin;
        if (s == 0) begin : g_first
            assign w_rin = '0;
            assign w_qin = '0;
            assign w_min = r_m;
            assign w_iin = r_it2;
        end else begin : g_next
            assign w_rin = r_rem[s-1];
            assign w_qin = r_root[s-1];
            assign w_min = r_sm[s-1];
            assign w_iin = r_sit[s-1];
        end
        assign w_cur = {w_rin[REMW-3:0], w_min[SQW-1-2*s -: 2]};
        assign w_t   = {w_qin, 2'b01};
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (w_cur >= w_t) begin
                    r_rem[s]  <= w_cur - w_t;
                    r_root[s] <= {w_qin[RW-2:0], 1'b1};
                end else begin
                    r_rem[s]  <= w_cur;
                    r_root[s] <= {w_qin[RW-2:0], 1'b0};
                end
                r_sm[s]  <= w_min;
                r_sit[s] <= w_iin;
            end
        end
    end

    // dividend with half-divisor rounding term
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_pn[i] <= DW'({r_sit[RW-1].mag[i], {(NW-1){1'b0}}})
                         + DW'(r_root[RW-1] >> 1);
            end
            r_pd   <= r_root[RW-1];
            r_pneg <= r_sit[RW-1].neg;
            r_pdeg <= r_sit[RW-1].deg;
        end
    end

    // restoring division, one quotient bit per stage, three lanes
    for (genvar s = 0; s < NW; s++) begin : g_div
        logic [RW-1:0] w_din;
        logic [2:0]    w_nin;
        logic          w_gin;
        if (s == 0) begin : g_first
            assign w_din = r_pd;
            assign w_nin = r_pneg;
            assign w_gin = r_pdeg;
        end else begin : g_next
            assign w_din = r_dd[s-1];
            assign w_nin = r_dneg[s-1];
            assign w_gin = r_ddeg[s-1];
        end
        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [RW:0]   w_rin, w_cur;
            logic [NW-1:0] w_lo, w_qin;
            if (s == 0) begin : g_first
                assign w_rin = (RW+1)'(r_pn[l] >> NW);
                assign w_lo  = r_pn[l][NW-1:0];
                assign w_qin = '0;
            end else begin : g_next
                assign w_rin = r_dr[s-1][l];
                assign w_lo  = r_dlo[s-1][l];
                assign w_qin = r_dq[s-1][l];
            end
            assign w_cur = {w_rin[RW-1:0], w_lo[NW-1-s]};
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    if (w_cur >= {1'b0, w_din}) begin
                        r_dr[s][l] <= w_cur - {1'b0, w_din};
                        r_dq[s][l] <= {w_qin[NW-2:0], 1'b1};
                    end else begin
                        r_dr[s][l] <= w_cur;
                        r_dq[s][l] <= {w_qin[NW-2:0], 1'b0};
                    end
                    r_dlo[s][l] <= w_lo;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dd[s]   <= w_din;
                r_dneg[s] <= w_nin;
                r_ddeg[s] <= w_gin;
            end
        end
    end

    // saturate, apply sign, zero on degenerate
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [NW-1:0] q;
            q = (r_dq[NW-1][i] > QMAX) ? QMAX : r_dq[NW-1][i];
            if (r_ddeg[NW-1])         n_o[i] = '0;
            else if (r_dneg[NW-1][i]) n_o[i] = -q;
            else                      n_o[i] = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o    <= n_o;
            r_odeg <= r_ddeg[NW-1];
        end
    end

    assign o_valid = r_ov;
    assign o_nx    = r_o[0];
    assign o_ny    = r_o[1];
    assign o_nz    = r_o[2];
    assign o_deg   = r_odeg;
endmodule
`default_nettype wire

// ----- hdl/triangle_face_normal.sv -----
`default_nettype none
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: v0_x..v2_z, 24 bits each
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: normal_x,y,z; tuser: degenerate
//
// one triangle per cycle sustained while m_axis_tready stays high; latency is set
// by the front, the queue head and the bit-per-stage root and divider in the back
// synchronous active-low reset clears valid bits, queue pointers and the credit count
// a stalled output freezes the back pipeline only; the front keeps running and
// s_axis_tready drops once 16 transactions are in the front or the queue
module triangle_face_normal import tfn_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [IDW-1:0] s_axis_tdata,  // v0_x v0_y v0_z v1_x .. v2_z from bit 0
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [ODW-1:0]      m_axis_tdata,  // normal_x normal_y normal_z from bit 0
    output logic [0:0]          m_axis_tuser   // degenerate
);
    logic           w_acc, w_push, w_pop, w_avail;
    t_item          w_fitem, w_head;
    logic [OCW-1:0] r_occ, n_occ;
    logic [NW-1:0]  w_nx, w_ny, w_nz;
    logic           w_deg;

    // credit count: transactions accepted but not yet taken from the queue,
    // so the front pipeline never has to stall
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_occ < OCW'(FD));
    assign n_occ         = r_occ + OCW'(w_acc) - OCW'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    // edges, cross product and normalizing shift
    tfn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc),
        .i_data  (s_axis_tdata),
        .o_valid (w_push),
        .o_item  (w_fitem)
    );

    tfn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_avail (w_avail)
    );

    // length, division and output register
    tfn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_head),
        .i_avail (w_avail),
        .o_pop   (w_pop),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_nx    (w_nx),
        .o_ny    (w_ny),
        .o_nz    (w_nz),
        .o_deg   (w_deg)
    );

    assign m_axis_tdata = ODW'({w_nz, w_ny, w_nx});
    assign m_axis_tuser = w_deg;
endmodule
`default_nettype wire
